// ----- src/ffbta_pkg.sv -----
// Shared types for the first-fit boundary-tag allocator.
// Holds the controller/datapath command and status bundles and the tag write selector.
// No dependencies.
package ffbta_pkg;

	// Which tag word a write step updates, and with what.
	typedef enum logic [3:0] {
		W_SETUP_HSZ,   // heap header size word = room
		W_SETUP_HAL,   // heap header allocated word = 0
		W_SETUP_FAL,   // heap footer allocated word = 0
		W_SETUP_FSZ,   // heap footer size word = room
		W_EXACT_HAL,   // exact fit: header allocated word = 1
		W_EXACT_FAL,   // exact fit: footer allocated word = 1
		W_SPLIT_HSZ,   // split: new header size word = size
		W_SPLIT_HAL,   // split: header allocated word = 1
		W_SPLIT_FAL,   // split: footer allocated word = 1
		W_SPLIT_FSZ,   // split: footer size word = size
		W_REST_HSZ,    // remainder header size word = rest
		W_REST_HAL,    // remainder header allocated word = 0
		W_REST_FSZ     // remainder footer size word = rest
	} wr_sel_t;

	typedef struct packed {
		logic     load_req;   // latch the request size
		logic     setup_chk;  // latch aligned heap bounds and room
		logic     set_ready;  // mark the heap as set up
		logic     init_walk;  // round the size, point at the first block
		logic     rd_en;      // issue a tag read
		logic     rd_alloc;   // read the allocated word instead of the size word
		logic     cap_sz;     // capture the size word just read
		logic     chk;        // latch next/mid/rest and step to the next block unless this one fits
		logic     wr_en;      // write one tag word
		wr_sel_t  wr_sel;
		logic     load_out;   // load the output register
		logic     grant;      // result kind for load_out
	} cmd_t;

	typedef struct packed {
		logic heap_ready;
		logic setup_ok;
		logic size_ok;
		logic in_heap;    // current block lies below the heap end
		logic fit;        // current block is free and large enough
		logic exact;      // current block size equals the request
		logic past_end;   // next block would start past the address space
	} status_t;

endpackage

// ----- src/ffbta_dpath.sv -----
// Datapath of the first-fit boundary-tag allocator: heap bounds, walk registers,
// tag memory and output register. Driven by ffbta_ctrl through ffbta_pkg::cmd_t.
// Depends on ffbta_pkg.
module ffbta_dpath #(
	parameter int ADDR_BITS = 16,
	parameter int TAG_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         heap_lower,
	input  logic [15:0]         heap_upper,
	input  logic [15:0]         s_tdata,     // [15:0] req_size
	input  ffbta_pkg::cmd_t     cmd,
	output ffbta_pkg::status_t  status,
	output logic [15:0]         m_tdata,     // [15:0] block_address
	output logic                m_tuser      // [0] granted
);

	localparam int WB  = TAG_BYTES / 2;
	localparam int WL  = $clog2(WB);
	localparam int IW  = ADDR_BITS - WL;
	localparam longint unsigned DEPTH = 64'd1 << IW;
	localparam int AW1 = ADDR_BITS + 1;
	localparam int SW  = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;

	localparam logic [ADDR_BITS-1:0] TA   = ADDR_BITS'(TAG_BYTES);
	localparam logic [ADDR_BITS-1:0] TM   = ADDR_BITS'(TAG_BYTES - 1);
	localparam logic [ADDR_BITS-1:0] T2A  = ADDR_BITS'(2 * TAG_BYTES);
	localparam logic [AW1-1:0]       T1   = AW1'(TAG_BYTES);
	localparam logic [AW1-1:0]       T2_1 = AW1'(2 * TAG_BYTES);
	localparam logic [AW1-1:0]       WB1  = AW1'(WB);
	localparam logic [AW1-1:0]       WB2  = AW1'(2 * WB);
	localparam logic [SW-1:0]        LIMIT = SW'((64'd1 << ADDR_BITS) - 64'(2 * TAG_BYTES));
	localparam logic [SW-1:0]        RND   = SW'(2 * TAG_BYTES - 1);
	localparam logic [ADDR_BITS-1:0] ONE  = ADDR_BITS'(1);

	logic [ADDR_BITS-1:0] tag_mem [DEPTH];
	logic [ADDR_BITS-1:0] rdata_q;

	logic                 heap_ready_q;
	logic [ADDR_BITS-1:0] heap_first_q, heap_end_q, room_q;
	logic [15:0]          req_q;
	logic [ADDR_BITS-1:0] size_q, blk_q, sz_q, rest_q;
	logic [AW1-1:0]       next_q, mid_q;
	logic                 out_grant_q;
	logic [15:0]          out_addr_q;

	logic [ADDR_BITS-1:0] lo, hi, start_c, stop_c, span_c, rest_c;
	logic [SW-1:0]        req_w, round_w;
	logic [AW1-1:0]       next_c, mid_c, rd_addr, wr_addr, bdata_c;
	logic [ADDR_BITS-1:0] wr_data;

	// Heap alignment from the live bound registers.
	always_comb begin
		lo      = ADDR_BITS'(heap_lower);
		hi      = ADDR_BITS'(heap_upper);
		start_c = ((lo + TM) & ~TM) | TA;
		stop_c  = ((hi - TA) & ~TM) | TA;
		span_c  = stop_c - start_c;
	end

	assign req_w   = SW'(req_q);
	assign round_w = (req_w + RND) & ~RND;

	assign next_c  = {1'b0, blk_q} + T2_1 + {1'b0, sz_q};
	assign mid_c   = {1'b0, blk_q} + T2_1 + {1'b0, size_q};
	assign rest_c  = sz_q - size_q - T2A;
	assign bdata_c = {1'b0, blk_q} + T1;

	always_comb begin
		status.heap_ready = heap_ready_q;
		status.setup_ok   = !(start_c < lo || stop_c > hi || start_c > stop_c || span_c < T2A);
		status.size_ok    = (req_q != 16'd0) && (req_w <= LIMIT);
		status.in_heap    = blk_q < heap_end_q;
		status.fit        = (sz_q >= size_q) && (rdata_q == '0);
		status.exact      = sz_q == size_q;
		status.past_end   = next_c[ADDR_BITS];
	end

	// Tag write address and data.
	always_comb begin
		unique case (cmd.wr_sel)
			ffbta_pkg::W_SETUP_HSZ: begin wr_addr = {1'b0, heap_first_q};       wr_data = room_q; end
			ffbta_pkg::W_SETUP_HAL: begin wr_addr = {1'b0, heap_first_q} + WB1; wr_data = '0;     end
			ffbta_pkg::W_SETUP_FAL: begin wr_addr = {1'b0, heap_end_q} - WB2;   wr_data = '0;     end
			ffbta_pkg::W_SETUP_FSZ: begin wr_addr = {1'b0, heap_end_q} - WB1;   wr_data = room_q; end
			ffbta_pkg::W_EXACT_HAL: begin wr_addr = {1'b0, blk_q} + WB1;        wr_data = ONE;    end
			ffbta_pkg::W_EXACT_FAL: begin wr_addr = next_q - WB2;               wr_data = ONE;    end
			ffbta_pkg::W_SPLIT_HSZ: begin wr_addr = {1'b0, blk_q};              wr_data = size_q; end
			ffbta_pkg::W_SPLIT_HAL: begin wr_addr = {1'b0, blk_q} + WB1;        wr_data = ONE;    end
			ffbta_pkg::W_SPLIT_FAL: begin wr_addr = mid_q - WB2;                wr_data = ONE;    end
			ffbta_pkg::W_SPLIT_FSZ: begin wr_addr = mid_q - WB1;                wr_data = size_q; end
			ffbta_pkg::W_REST_HSZ:  begin wr_addr = mid_q;                      wr_data = rest_q; end
			ffbta_pkg::W_REST_HAL:  begin wr_addr = mid_q + WB1;                wr_data = '0;     end
			ffbta_pkg::W_REST_FSZ:  begin wr_addr = next_q - WB1;               wr_data = rest_q; end
			default:                begin wr_addr = {1'b0, heap_first_q};       wr_data = room_q; end
		endcase
	end

	assign rd_addr = cmd.rd_alloc ? ({1'b0, blk_q} + WB1) : {1'b0, blk_q};

	// Tag memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			tag_mem[wr_addr[ADDR_BITS-1:WL]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= tag_mem[rd_addr[ADDR_BITS-1:WL]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_ready_q <= 1'b0;
			heap_first_q <= '0;
			heap_end_q   <= '0;
		end else begin
			if (cmd.setup_chk) begin
				heap_first_q <= start_c;
				heap_end_q   <= stop_c;
			end
			if (cmd.set_ready) begin
				heap_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= s_tdata;
		end
		if (cmd.setup_chk) begin
			room_q <= span_c - T2A;
		end
		if (cmd.init_walk) begin
			size_q <= ADDR_BITS'(round_w);
			blk_q  <= heap_first_q;
		end
		if (cmd.cap_sz) begin
			sz_q <= rdata_q;
		end
		if (cmd.chk) begin
			next_q <= next_c;
			mid_q  <= mid_c;
			rest_q <= rest_c;
			// hold the block that fits for the tag updates and the result
			if (!status.fit) begin
				blk_q <= next_c[ADDR_BITS-1:0];
			end
		end
		if (cmd.load_out) begin
			out_grant_q <= cmd.grant;
			out_addr_q  <= cmd.grant ? 16'(bdata_c) : 16'd0;
		end
	end

	assign m_tdata = out_addr_q;
	assign m_tuser = out_grant_q;

endmodule

// ----- src/ffbta_ctrl.sv -----
// Controller of the first-fit boundary-tag allocator: sequences setup, size check,
// tag walk, tag updates and result hand-off. Depends on ffbta_pkg.
module ffbta_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  ffbta_pkg::status_t  status,
	output ffbta_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		IDLE, SETUP_CHK, SETUP_WR, SIZE_CHK, WALK, RD_HDR, RD_ALLOC, CHK,
		EXACT_WR, SPLIT_WR, FINISH
	} state_t;

	state_t     state_q;
	logic [2:0] wstep_q;
	logic       grant_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = state_q == IDLE;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.wr_sel = ffbta_pkg::W_SETUP_HSZ;
		unique case (state_q)
			IDLE:      cmd.load_req = s_tvalid;
			SETUP_CHK: cmd.setup_chk = status.setup_ok;
			SETUP_WR: begin
				cmd.wr_en = 1'b1;
				unique case (wstep_q)
					3'd0:    cmd.wr_sel = ffbta_pkg::W_SETUP_HSZ;
					3'd1:    cmd.wr_sel = ffbta_pkg::W_SETUP_HAL;
					3'd2:    cmd.wr_sel = ffbta_pkg::W_SETUP_FAL;
					default: cmd.wr_sel = ffbta_pkg::W_SETUP_FSZ;
				endcase
				cmd.set_ready = wstep_q == 3'd3;
			end
			SIZE_CHK:  cmd.init_walk = status.size_ok;
			WALK:      cmd.rd_en = status.in_heap;
			RD_HDR: begin
				// size word is in the read register now; fetch the allocated word
				cmd.rd_en    = 1'b1;
				cmd.rd_alloc = 1'b1;
				cmd.cap_sz   = 1'b1;
			end
			RD_ALLOC:  ;
			CHK:       cmd.chk = 1'b1;
			EXACT_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = (wstep_q == 3'd0) ? ffbta_pkg::W_EXACT_HAL : ffbta_pkg::W_EXACT_FAL;
			end
			SPLIT_WR: begin
				cmd.wr_en = 1'b1;
				unique case (wstep_q)
					3'd0:    cmd.wr_sel = ffbta_pkg::W_SPLIT_HSZ;
					3'd1:    cmd.wr_sel = ffbta_pkg::W_SPLIT_HAL;
					3'd2:    cmd.wr_sel = ffbta_pkg::W_SPLIT_FAL;
					3'd3:    cmd.wr_sel = ffbta_pkg::W_SPLIT_FSZ;
					3'd4:    cmd.wr_sel = ffbta_pkg::W_REST_HSZ;
					3'd5:    cmd.wr_sel = ffbta_pkg::W_REST_HAL;
					default: cmd.wr_sel = ffbta_pkg::W_REST_FSZ;
				endcase
			end
			FINISH: begin
				cmd.load_out = out_free;
				cmd.grant    = grant_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			wstep_q     <= '0;
			grant_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= status.heap_ready ? SIZE_CHK : SETUP_CHK;
					end
				end
				SETUP_CHK: begin
					wstep_q <= '0;
					grant_q <= 1'b0;
					state_q <= status.setup_ok ? SETUP_WR : FINISH;
				end
				SETUP_WR: begin
					wstep_q <= wstep_q + 3'd1;
					if (wstep_q == 3'd3) begin
						state_q <= SIZE_CHK;
					end
				end
				SIZE_CHK: begin
					grant_q <= 1'b0;
					state_q <= status.size_ok ? WALK : FINISH;
				end
				WALK:     state_q <= status.in_heap ? RD_HDR : FINISH;
				RD_HDR:   state_q <= RD_ALLOC;
				RD_ALLOC: state_q <= CHK;
				CHK: begin
					wstep_q <= '0;
					priority if (status.fit) begin
						grant_q <= 1'b1;
						state_q <= status.exact ? EXACT_WR : SPLIT_WR;
					end else if (status.past_end) begin
						state_q <= FINISH;
					end else begin
						state_q <= WALK;
					end
				end
				EXACT_WR: begin
					wstep_q <= wstep_q + 3'd1;
					if (wstep_q == 3'd1) begin
						state_q <= FINISH;
					end
				end
				SPLIT_WR: begin
					wstep_q <= wstep_q + 3'd1;
					if (wstep_q == 3'd6) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("output register loaded while a word is still held");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted before the first completed");

	a_fit_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CHK && status.fit) |=> (cmd.wr_en && grant_q))
		else $error("fitting block not followed by a tag update");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !(cmd.rd_en || cmd.load_out || s_tready))
		else $error("tag write overlaps a read, result load or input accept");

endmodule

// ----- src/first_fit_boundary_tag_allocator.sv -----
// Top level of the first-fit boundary-tag allocator: APB bound registers and the
// controller/datapath pair. Depends on ffbta_pkg, ffbta_ctrl and ffbta_dpath.
//
// Usage:
//   Slave stream (s_*): one word per allocation request, s_tdata[15:0] = req_size.
//   Master stream (m_*): one word per request, m_tdata[15:0] = block_address
//   (data area byte address, 0 on failure), m_tuser = granted.
//   APB port: heap_lower at 0x0, heap_upper at 0x4; write them while idle.
//   Bounds take effect at the next heap setup, which runs on the first request
//   after reset and on every request after a failed setup.
// Sequence: a setup, when it runs, writes the heap header and footer tags; the walk
//   reads the size and then the allocated word of each visited block; a fitting block
//   takes 2 (exact fit) or 7 (split) tag writes. A zero or oversize size ends without
//   a walk. The walk is bound by the tag memory: two reads per block, one write per
//   tag word.
// Throughput: one request at a time; s_tready is high only while idle, and a
//   new request is taken while the previous result still waits in the output
//   register. A stalled receiver holds the result; the next one waits for it.
// Reset: asynchronous, clears the control state, the "heap set up" flag and
//   the bound registers (lower 0, upper 0xFFFF). The tag memory is not cleared;
//   setup writes every tag the walk later reads.
// TAG_BYTES is 4 or 8.
module first_fit_boundary_tag_allocator #(
	parameter int ADDR_BITS = 16,
	parameter int TAG_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] req_size
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] block_address
	output logic        m_tuser,    // [0] granted
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] heap_lower_q, heap_upper_q;
	logic        cfg_wr;

	ffbta_pkg::cmd_t    cmd;
	ffbta_pkg::status_t status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register select is paddr[2]; byte offset bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_lower_q <= 16'h0000;
			heap_upper_q <= 16'hFFFF;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				heap_upper_q <= pwdata[15:0];
			end else begin
				heap_lower_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = {16'h0000, paddr[2] ? heap_upper_q : heap_lower_q};

	ffbta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ffbta_dpath #(
		.ADDR_BITS (ADDR_BITS),
		.TAG_BYTES (TAG_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.heap_lower (heap_lower_q),
		.heap_upper (heap_upper_q),
		.s_tdata    (s_tdata),
		.cmd        (cmd),
		.status     (status),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ----- sim/first_fit_boundary_tag_allocator_tb.sv -----
`timescale 1ns / 100ps
// Testbench for first_fit_boundary_tag_allocator: APB heap bound writes plus a stream
// of allocation requests, each grant predicted by a behavioral heap walker.
// Depends only on the allocator RTL (default parameters, 16-bit address, 4-byte tags).
module first_fit_boundary_tag_allocator_tb;

	// Tag geometry of the default build: two 2-byte words per tag, blocks in 8-byte steps.
	localparam int TAG_BYTES  = 4;
	localparam int WORD_BYTES = TAG_BYTES / 2;
	localparam int GRAIN      = 2 * TAG_BYTES;
	localparam int MAX_REQ    = 65536 - GRAIN;
	localparam int TAG_DEPTH  = 65536 / WORD_BYTES;

	// APB register map.
	localparam logic [2:0] REG_HEAP_LOWER = 3'd0;
	localparam logic [2:0] REG_HEAP_UPPER = 3'd4;

	// Watchdog limit, set well above the length of a full walk over the heap.
	localparam int STALL_LIMIT = 60000;
	localparam int MAX_REPORTS = 10;

	// Wide addresses so that sums past the 16-bit space stay visible.
	typedef logic [63:0] addr_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] block_address;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;          // [15:0] req_size
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [15:0] block_address
	logic        m_tuser;          // [0] granted
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Expected grants, oldest first; one per accepted request word.
	grant_t pending_grants[$];

	// Behavioral copy of the heap: tag words, bound registers and setup state.
	logic [15:0] tag_words [TAG_DEPTH] = '{default: '0};
	logic [15:0] bound_lower = 16'h0000;
	logic [15:0] bound_upper = 16'hFFFF;
	bit          heap_built = 1'b0;
	addr_t       heap_start = '0;
	addr_t       heap_stop = '0;

	int mismatches = 0;
	int stalled_cycles = 0;
	int rx_hold = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	first_fit_boundary_tag_allocator #(
		.ADDR_BITS(16),
		.TAG_BYTES(TAG_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 4 ns clock, first rising edge at 2 ns.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Heap model
	// ------------------------------------------------------------------

	// Tag word index wraps modulo the store depth.
	function automatic logic [15:0] tag_at(addr_t a);
		return tag_words[(a / WORD_BYTES) % TAG_DEPTH];
	endfunction

	function automatic void put_tag(addr_t a, addr_t v);
		tag_words[(a / WORD_BYTES) % TAG_DEPTH] = v[15:0];
	endfunction

	// Align the bounds and lay one free block across the heap; 0 if there is no room.
	function automatic bit build_heap();
		addr_t lo;
		addr_t hi;
		addr_t start;
		addr_t stop;
		addr_t room;
		lo = bound_lower;
		hi = bound_upper;
		start = (((lo + TAG_BYTES - 1) & ~addr_t'(TAG_BYTES - 1)) | TAG_BYTES) & 64'hFFFF;
		// hi below one tag wraps far up and is then cut back to 16 bits
		stop = (((hi - TAG_BYTES) & ~addr_t'(TAG_BYTES - 1)) | TAG_BYTES) & 64'hFFFF;
		if (start < lo || stop > hi || start > stop || stop - start < GRAIN)
			return 1'b0;
		room = stop - start - GRAIN;
		put_tag(start, room);
		put_tag(start + WORD_BYTES, 0);
		put_tag(stop - 2 * WORD_BYTES, 0);
		put_tag(stop - WORD_BYTES, room);
		heap_start = start;
		heap_stop = stop;
		return 1'b1;
	endfunction

	// Serve one request against the model heap and return the grant it must produce.
	function automatic grant_t predict_grant(logic [15:0] req);
		grant_t g;
		addr_t  want;
		addr_t  blk;
		addr_t  sz;
		addr_t  nxt;
		addr_t  mid;
		addr_t  rest;
		g = '0;
		// setup runs on the first request and again after every failed one
		if (!heap_built) begin
			heap_built = build_heap();
			if (!heap_built)
				return g;
		end
		if (req == 0 || req > MAX_REQ)
			return g;
		want = (addr_t'(req) + GRAIN - 1) & ~addr_t'(GRAIN - 1);
		blk = heap_start;
		while (blk < heap_stop) begin
			sz = tag_at(blk);
			nxt = blk + GRAIN + sz;
			if (sz >= want && tag_at(blk + WORD_BYTES) == 0) begin
				if (sz == want) begin
					put_tag(blk + WORD_BYTES, 1);
					put_tag(nxt - 2 * WORD_BYTES, 1);
				end else begin
					// split: allocated front part, free remainder behind it
					mid = blk + GRAIN + want;
					rest = (sz - want - GRAIN) & 64'hFFFF;
					put_tag(blk, want);
					put_tag(blk + WORD_BYTES, 1);
					put_tag(mid - 2 * WORD_BYTES, 1);
					put_tag(mid - WORD_BYTES, want);
					put_tag(mid, rest);
					put_tag(mid + WORD_BYTES, 0);
					put_tag(nxt - WORD_BYTES, rest);
				end
				g.granted = 1'b1;
				g.block_address = 16'(blk + TAG_BYTES);
				return g;
			end
			// a chain running past the address space ends the walk as a failure
			if (nxt > 64'hFFFF)
				break;
			blk = nxt;
		end
		return g;
	endfunction

	// ------------------------------------------------------------------
	// Bus drivers
	// ------------------------------------------------------------------

	// Mostly short gaps, a few long ones, none while steady.
	function automatic int pick_gap(bit steady);
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request word, wait for its handshake, then log the expected grant.
	// Called on a rising edge; valid stays high into the next call unless a gap drops it.
	task automatic send_request(input logic [15:0] req);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
		pending_grants.push_back(predict_grant(req));
	endtask

	// Drop valid and hold until every outstanding grant is back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle and access cycle, then psel low again.
	// Upper data bits carry junk; the registers are 16 bits wide.
	task automatic write_bound(input logic [2:0] reg_addr, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= reg_addr;
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_addr == REG_HEAP_LOWER)
			bound_lower = value;
		else
			bound_upper = value;
		@(posedge clk);
	endtask

	// Receiver: random backpressure, short stalls mostly, some long ones.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				rx_hold <= pick_gap(rx_steady);
		end
	end

	// Compare every accepted result word against the oldest expected grant.
	always @(posedge clk) begin : check_grants
		grant_t exp_grant;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result word granted=%0b addr=0x%04h",
						$time, m_tuser, m_tdata);
			end else begin
				exp_grant = pending_grants.pop_front();
				if (m_tuser !== exp_grant.granted || m_tdata !== exp_grant.block_address) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: grant mismatch, expected granted=%0b addr=0x%04h, got granted=%0b addr=0x%04h",
							$time, exp_grant.granted, exp_grant.block_address,
							m_tuser, m_tdata);
				end
			end
		end
	end

	// Watchdog: end the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			stalled_cycles = 0;
		else if (arst_n)
			stalled_cycles = stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Bounds that leave no room: setup fails, and each request retries it.
	// Covers both register extremes and the wrap of an aligned lower bound.
	task automatic test_failed_setup();
		logic [15:0] lows  [6] = '{16'hFFFF, 16'h0000, 16'h0000, 16'd300, 16'd100, 16'd65530};
		logic [15:0] highs [6] = '{16'hFFFF, 16'h0000, 16'h0007, 16'd200, 16'd107, 16'hFFFF};
		logic [15:0] sizes [6] = '{16'd0, 16'hFFFF, 16'd1, 16'd8, 16'h8000, 16'h7FFF};
		for (int i = 0; i < 6; i++) begin
			drain();
			write_bound(REG_HEAP_LOWER, lows[i]);
			write_bound(REG_HEAP_UPPER, highs[i]);
			send_request(sizes[i]);
		end
		drain();
	endtask

	// Unaligned bounds that set up a mid-sized heap, then the request size edges:
	// zero (after setup), oversize, largest legal size, rounding around the grain.
	task automatic test_heap_edges();
		logic [15:0] sizes [18] = '{
			16'd0, 16'hFFFF, 16'd65529, 16'd65528, 16'd1, 16'd7, 16'd8, 16'd9,
			16'd15, 16'd16, 16'd17, 16'd2048, 16'h8000, 16'h5555, 16'hAAAA,
			16'd24, 16'd3, 16'h7FFF};
		write_bound(REG_HEAP_LOWER, 16'd1001);
		write_bound(REG_HEAP_UPPER, 16'd20003);
		foreach (sizes[i])
			send_request(sizes[i]);
		drain();
	endtask

	// Once the heap is up, new bounds must not move it.
	task automatic test_ignored_bounds();
		write_bound(REG_HEAP_LOWER, 16'h8000);
		write_bound(REG_HEAP_UPPER, 16'h8100);
		repeat (5)
			send_request(16'($urandom_range(1, 40)));
		drain();
	endtask

	// Random requests: mostly small and medium so the heap fills up gradually,
	// some full-range and out-of-range sizes, and requests that fit the first free block
	// exactly once it has shrunk. Idling switches between steady and bursty.
	task automatic test_random_requests(input int count);
		int          roll;
		logic [15:0] req;
		addr_t       blk;
		addr_t       sz;
		addr_t       free_tail;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0) begin
				tx_steady = ($urandom_range(0, 4) == 0);
				rx_steady = ($urandom_range(0, 4) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 65)
				req = 16'($urandom_range(1, 48));
			else if (roll < 77)
				req = 16'($urandom_range(49, 600));
			else if (roll < 87)
				req = 16'($urandom);
			else if (roll < 91)
				req = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(MAX_REQ + 1, 65535));
			else begin
				// find the first free block with room in it
				free_tail = 0;
				blk = heap_start;
				while (blk < heap_stop) begin
					sz = tag_at(blk);
					if (sz != 0 && tag_at(blk + WORD_BYTES) == 0) begin
						free_tail = sz;
						break;
					end
					blk = blk + GRAIN + sz;
				end
				if (free_tail != 0 && free_tail <= 512)
					req = 16'(free_tail - $urandom_range(0, GRAIN - 1));
				else
					req = 16'($urandom_range(1, 48));
			end
			send_request(req);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_failed_setup();
		test_heap_edges();
		test_ignored_bounds();
		test_random_requests(360);
		drain();

		if (mismatches == 0 && pending_grants.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
